@@ src/rvd_pkg.sv @@
package rvd_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned REG_W  = 5;

	localparam logic [6:0] OPC_LUI    = 7'd55;
	localparam logic [6:0] OPC_AUIPC  = 7'd23;
	localparam logic [6:0] OPC_JAL    = 7'd111;
	localparam logic [6:0] OPC_BRANCH = 7'd99;
	localparam logic [6:0] OPC_JALR   = 7'd103;
	localparam logic [6:0] OPC_LOAD   = 7'd3;
	localparam logic [6:0] OPC_OPIMM  = 7'd19;
	localparam logic [6:0] OPC_STORE  = 7'd35;
	localparam logic [6:0] OPC_OP     = 7'd51;

	localparam logic [6:0] F7_BASE = 7'd0;
	localparam logic [6:0] F7_ALT  = 7'd32;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SRL = 3'd5;

	typedef enum logic [2:0] {
		FMT_U = 3'd0,
		FMT_J = 3'd1,
		FMT_I = 3'd2,
		FMT_B = 3'd3,
		FMT_S = 3'd4,
		FMT_R = 3'd5
	} fmt_t;

	typedef enum logic [5:0] {
		MN_LUI   = 6'd0,
		MN_AUIPC = 6'd1,
		MN_JAL   = 6'd2,
		MN_JALR  = 6'd3,
		MN_LB    = 6'd4,
		MN_LH    = 6'd5,
		MN_LW    = 6'd6,
		MN_LBU   = 6'd7,
		MN_LHU   = 6'd8,
		MN_SB    = 6'd9,
		MN_SH    = 6'd10,
		MN_SW    = 6'd11,
		MN_ADDI  = 6'd12,
		MN_SLTI  = 6'd13,
		MN_SLTIU = 6'd14,
		MN_XORI  = 6'd15,
		MN_ORI   = 6'd16,
		MN_ANDI  = 6'd17,
		MN_SLLI  = 6'd18,
		MN_SRLI  = 6'd19,
		MN_SRAI  = 6'd20,
		MN_BEQ   = 6'd21,
		MN_BNE   = 6'd22,
		MN_BLT   = 6'd23,
		MN_BGE   = 6'd24,
		MN_BLTU  = 6'd25,
		MN_BGEU  = 6'd26,
		MN_ADD   = 6'd27,
		MN_SUB   = 6'd28,
		MN_SLL   = 6'd29,
		MN_SLT   = 6'd30,
		MN_SLTU  = 6'd31,
		MN_XOR   = 6'd32,
		MN_SRL   = 6'd33,
		MN_SRA   = 6'd34,
		MN_OR    = 6'd35,
		MN_AND   = 6'd36
	} mnem_t;

	typedef struct packed {
		logic                     ok;
		fmt_t                     fmt;
		mnem_t                    mnem;
		logic [REG_W-1:0]         rd;
		logic [REG_W-1:0]         rs1;
		logic [REG_W-1:0]         rs2;
		logic signed [WORD_W-1:0] imm;
	} dec_res_t;

endpackage

@@ src/rvd_decode.sv @@
module rvd_decode
	import rvd_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	output dec_res_t          res
);

	logic [6:0]       opc;
	logic [2:0]       f3;
	logic [6:0]       f7;
	logic [REG_W-1:0] rd;
	logic [REG_W-1:0] rs1;
	logic [REG_W-1:0] rs2;
	dec_res_t         d;

	assign opc = word[6:0];
	assign rd  = word[11:7];
	assign f3  = word[14:12];
	assign rs1 = word[19:15];
	assign rs2 = word[24:20];
	assign f7  = word[31:25];

	always_comb begin
		d      = '0;
		d.ok   = 1'b1;
		d.fmt  = FMT_U;
		d.mnem = MN_LUI;
		case (opc)
			OPC_LUI, OPC_AUIPC: begin
				d.fmt  = FMT_U;
				d.mnem = (opc == OPC_LUI) ? MN_LUI : MN_AUIPC;
				d.imm  = {word[31:12], 12'd0};
				d.rd   = rd;
			end
			OPC_JAL: begin
				d.fmt  = FMT_J;
				d.mnem = MN_JAL;
				d.imm  = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
				d.rd   = rd;
			end
			OPC_JALR, OPC_LOAD, OPC_OPIMM: begin
				d.fmt = FMT_I;
				d.imm = {{20{word[31]}}, word[31:20]};
				d.rd  = rd;
				d.rs1 = rs1;
				if (opc == OPC_JALR) begin
					d.mnem = MN_JALR;
					d.ok   = (f3 == F3_ADD);
				end else if (opc == OPC_LOAD) begin
					case (f3)
						3'd0: d.mnem = MN_LB;
						3'd1: d.mnem = MN_LH;
						3'd2: d.mnem = MN_LW;
						3'd4: d.mnem = MN_LBU;
						3'd5: d.mnem = MN_LHU;
						default: d.ok = 1'b0;
					endcase
				end else begin
					case (f3)
						3'd0: d.mnem = MN_ADDI;
						3'd1: d.mnem = MN_SLLI;
						3'd2: d.mnem = MN_SLTI;
						3'd3: d.mnem = MN_SLTIU;
						3'd4: d.mnem = MN_XORI;
						3'd5: d.mnem = MN_SRLI;
						3'd6: d.mnem = MN_ORI;
						default: d.mnem = MN_ANDI;
					endcase
					// Shifts carry the shift amount in both rs2 and the immediate.
					if (f3 == F3_SLL || f3 == F3_SRL) begin
						d.rs2 = rs2;
						d.imm = {{(WORD_W-REG_W){1'b0}}, rs2};
						if (f3 == F3_SRL && f7 == F7_ALT) begin
							d.mnem = MN_SRAI;
						end else if (f7 != F7_BASE) begin
							d.ok = 1'b0;
						end
					end
				end
			end
			OPC_BRANCH: begin
				d.fmt = FMT_B;
				d.imm = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
				d.rs1 = rs1;
				d.rs2 = rs2;
				case (f3)
					3'd0: d.mnem = MN_BEQ;
					3'd1: d.mnem = MN_BNE;
					3'd4: d.mnem = MN_BLT;
					3'd5: d.mnem = MN_BGE;
					3'd6: d.mnem = MN_BLTU;
					3'd7: d.mnem = MN_BGEU;
					default: d.ok = 1'b0;
				endcase
			end
			OPC_STORE: begin
				d.fmt = FMT_S;
				d.imm = {{20{word[31]}}, word[31:25], word[11:7]};
				d.rs1 = rs1;
				d.rs2 = rs2;
				case (f3)
					3'd0: d.mnem = MN_SB;
					3'd1: d.mnem = MN_SH;
					3'd2: d.mnem = MN_SW;
					default: d.ok = 1'b0;
				endcase
			end
			OPC_OP: begin
				d.fmt = FMT_R;
				d.rd  = rd;
				d.rs1 = rs1;
				d.rs2 = rs2;
				if (f7 == F7_BASE) begin
					case (f3)
						3'd0: d.mnem = MN_ADD;
						3'd1: d.mnem = MN_SLL;
						3'd2: d.mnem = MN_SLT;
						3'd3: d.mnem = MN_SLTU;
						3'd4: d.mnem = MN_XOR;
						3'd5: d.mnem = MN_SRL;
						3'd6: d.mnem = MN_OR;
						default: d.mnem = MN_AND;
					endcase
				end else if (f7 == F7_ALT && f3 == F3_ADD) begin
					d.mnem = MN_SUB;
				end else if (f7 == F7_ALT && f3 == F3_SRL) begin
					d.mnem = MN_SRA;
				end else begin
					d.ok = 1'b0;
				end
			end
			default: d.ok = 1'b0;
		endcase
	end

	// An undecodable word reports all fields as zero.
	assign res = d.ok ? d : '0;

endmodule

@@ src/rv32i_instruction_decoder.sv @@
// RV32I decoder: a word is taken whenever start is high (busy never rises), and its
// decoded result appears for one cycle, with done high, after the word register and the
// result register; one word per cycle is sustained. The registered instruction word is
// decoded in combinational logic into the result register. The receiver cannot stall
// the results, so each must be captured in the cycle that done marks it.
module rv32i_instruction_decoder
	import rvd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [WORD_W-1:0]        instruction_word,
	output logic                     done,
	output logic                     valid_res,
	output logic [2:0]               format,
	output logic [5:0]               mnemonic,
	output logic [REG_W-1:0]         dest_reg,
	output logic [REG_W-1:0]         src1_reg,
	output logic [REG_W-1:0]         src2_reg,
	output logic signed [WORD_W-1:0] immediate
);

	logic              vld_s1;
	logic [WORD_W-1:0] word_s1;
	logic              vld_s2;
	dec_res_t          dec;
	dec_res_t          res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_s1 <= instruction_word;
		end
		if (vld_s1) begin
			res_s2 <= dec;
		end
	end

	rvd_decode u_decode (
		.word (word_s1),
		.res  (dec)
	);

	assign done      = vld_s2;
	assign valid_res = res_s2.ok;
	assign format    = res_s2.fmt;
	assign mnemonic  = res_s2.mnem;
	assign dest_reg  = res_s2.rd;
	assign src1_reg  = res_s2.rs1;
	assign src2_reg  = res_s2.rs2;
	assign immediate = res_s2.imm;

`ifndef ASSERT_OFF
	a_two_cycle_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done)
		else $error("decoded word did not produce a result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (immediate == '0 && mnemonic == 6'd0 && dest_reg == '0))
		else $error("invalid result carries nonzero fields");

	a_r_no_imm: assert property (@(posedge clk) disable iff (!arst_n)
		(done && valid_res && format == FMT_R) |-> (immediate == '0))
		else $error("register format result has an immediate");

	a_branch_even: assert property (@(posedge clk) disable iff (!arst_n)
		(done && valid_res && (format == FMT_B || format == FMT_J)) |-> !immediate[0])
		else $error("branch or jump offset is odd");
`endif

endmodule
